### rtl/core/mts_pkg.sv
`default_nettype none
package mts_pkg;

    localparam int MAX_VERTS  = 4096;
    localparam int COORD_BITS = 32;
    localparam int IDX_W      = $clog2(MAX_VERTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int VERT_W     = 3 * COORD_BITS;

    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_SPLIT  = 2'd1;
    localparam logic [1:0] ACT_END    = 2'd2;

    localparam logic KIND_VERTEX   = 1'b0;
    localparam logic KIND_TRIANGLE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_APPEND,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } coord_t;

    typedef struct packed {
        logic [1:0]                   action;
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] pos_z;
        logic [IDX_W-1:0]             corner_a;
        logic [IDX_W-1:0]             corner_b;
        logic [IDX_W-1:0]             corner_c;
    } cmd_t;

    typedef struct packed {
        logic                         kind;
        logic [IDX_W-1:0]             vertex_index;
        logic signed [COORD_BITS-1:0] out_x;
        logic signed [COORD_BITS-1:0] out_y;
        logic signed [COORD_BITS-1:0] out_z;
        logic [IDX_W-1:0]             tri_first;
        logic [IDX_W-1:0]             tri_second;
        logic [IDX_W-1:0]             tri_third;
        logic                         store_full;
        logic                         last;
    } rsp_t;

    function automatic logic signed [COORD_BITS-1:0] half_sum(
        input logic signed [COORD_BITS-1:0] p,
        input logic signed [COORD_BITS-1:0] q
    );
        logic signed [COORD_BITS:0] s;
        begin
            s = {p[COORD_BITS-1], p} + {q[COORD_BITS-1], q};
            half_sum = s[COORD_BITS:1];
        end
    endfunction

endpackage
`default_nettype wire

### rtl/core/mts_ram.sv
`default_nettype none
module mts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### rtl/core/midpoint_triangle_subdivider.sv
// channel  | signals              | transfer
// ---------+----------------------+-----------------------------------
// command  | start, busy, cmd     | word taken when start && !busy
// result   | strobe, result       | word valid for one cycle on strobe
//
// Load and end-pass words never raise busy. A subdivide word holds busy while
// it reads the three corners, reads the store once per midpoint table entry
// and drains the two-deep read pipe, appends each midpoint not found there and
// fills the seven result slots. The last result is on the ports in the cycle in
// which busy falls. rst_n clears the counts; store contents are undefined until
// written. The receiver cannot stall.
`default_nettype none
module midpoint_triangle_subdivider (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire mts_pkg::cmd_t   cmd,
    output logic                 strobe,
    output mts_pkg::rsp_t        result
);

    mts_pkg::state_t state_reg, state_next;

    logic [mts_pkg::CNT_W-1:0] store_cnt_reg, store_cnt_next;
    logic [mts_pkg::CNT_W-1:0] tbl_cnt_reg, tbl_cnt_next;
    logic [mts_pkg::CNT_W-1:0] issue_reg, issue_next;
    logic                      v1_reg, v1_next, v2_reg, v2_next;
    logic [1:0]                rcnt_reg, rcnt_next;
    logic [2:0]                ocnt_reg, ocnt_next;
    logic [mts_pkg::IDX_W-1:0] s2_reg, s2_next;

    logic [mts_pkg::IDX_W-1:0] ca_reg, ca_next, cb_reg, cb_next, cc_reg, cc_next;
    mts_pkg::coord_t           pa_reg, pa_next, pb_reg, pb_next;
    mts_pkg::coord_t           mid_reg [3];
    mts_pkg::coord_t           mid_next [3];
    logic [mts_pkg::IDX_W-1:0] midx_reg [3];
    logic [mts_pkg::IDX_W-1:0] midx_next [3];
    logic [2:0]                found_reg, found_next;
    logic                      full_reg, full_next;

    logic                      strobe_reg, strobe_next;
    mts_pkg::rsp_t             result_reg, result_next;

    logic                      st_we;
    logic [mts_pkg::IDX_W-1:0] st_waddr, st_raddr;
    mts_pkg::coord_t           st_wdata, st_rdata;
    logic                      tb_we;
    logic [mts_pkg::IDX_W-1:0] tb_waddr, tb_wdata, tb_raddr, tb_rdata;

    logic                      accept;
    logic [1:0]                eidx;
    logic                      scan_done;

    mts_ram #(.WIDTH(mts_pkg::VERT_W), .DEPTH(mts_pkg::MAX_VERTS)) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    mts_ram #(.WIDTH(mts_pkg::IDX_W), .DEPTH(mts_pkg::MAX_VERTS)) u_table (
        .clk   (clk),
        .we    (tb_we),
        .waddr (tb_waddr),
        .wdata (tb_wdata),
        .raddr (tb_raddr),
        .rdata (tb_rdata)
    );

    assign accept    = start && (state_reg == mts_pkg::ST_IDLE);
    assign busy      = (state_reg != mts_pkg::ST_IDLE);
    assign strobe    = strobe_reg;
    assign result    = result_reg;
    assign eidx      = rcnt_reg;
    assign scan_done = (issue_reg == tbl_cnt_reg) && !v1_reg && !v2_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mts_pkg::ST_IDLE:
            begin
                if (accept && cmd.action == mts_pkg::ACT_SPLIT)
                begin
                    state_next = mts_pkg::ST_READ;
                end
            end
            mts_pkg::ST_READ:
            begin
                if (rcnt_reg == 2'd3)
                begin
                    state_next = mts_pkg::ST_SCAN;
                end
            end
            mts_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = mts_pkg::ST_APPEND;
                end
            end
            mts_pkg::ST_APPEND:
            begin
                if (rcnt_reg == 2'd2)
                begin
                    state_next = mts_pkg::ST_EMIT;
                end
            end
            mts_pkg::ST_EMIT:
            begin
                if (ocnt_reg == 3'd6)
                begin
                    state_next = mts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mts_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        store_cnt_next = store_cnt_reg;
        tbl_cnt_next   = tbl_cnt_reg;
        issue_next     = issue_reg;
        v1_next        = 1'b0;
        v2_next        = v1_reg;
        rcnt_next      = rcnt_reg;
        ocnt_next      = ocnt_reg;
        s2_next        = tb_rdata;
        ca_next        = ca_reg;
        cb_next        = cb_reg;
        cc_next        = cc_reg;
        pa_next        = pa_reg;
        pb_next        = pb_reg;
        mid_next       = mid_reg;
        midx_next      = midx_reg;
        found_next     = found_reg;
        full_next      = full_reg;
        strobe_next    = 1'b0;
        result_next    = result_reg;
        st_we          = 1'b0;
        st_waddr       = store_cnt_reg[mts_pkg::IDX_W-1:0];
        st_wdata       = '{x: cmd.pos_x, y: cmd.pos_y, z: cmd.pos_z};
        st_raddr       = tb_rdata;
        tb_we          = 1'b0;
        tb_waddr       = tbl_cnt_reg[mts_pkg::IDX_W-1:0];
        tb_wdata       = store_cnt_reg[mts_pkg::IDX_W-1:0];
        tb_raddr       = issue_reg[mts_pkg::IDX_W-1:0];

        unique case (state_reg)
            mts_pkg::ST_IDLE:
            begin
                rcnt_next = 2'd0;
                ocnt_next = 3'd0;
                if (accept)
                begin
                    priority if (cmd.action == mts_pkg::ACT_LOAD)
                    begin
                        if (store_cnt_reg < mts_pkg::CNT_W'(mts_pkg::MAX_VERTS))
                        begin
                            st_we          = 1'b1;
                            store_cnt_next = store_cnt_reg + 1'b1;
                        end
                    end
                    else if (cmd.action == mts_pkg::ACT_END)
                    begin
                        tbl_cnt_next = '0;
                    end
                    else if (cmd.action == mts_pkg::ACT_SPLIT)
                    begin
                        ca_next = cmd.corner_a;
                        cb_next = cmd.corner_b;
                        cc_next = cmd.corner_c;
                    end
                    else
                    begin
                        ca_next = ca_reg;
                    end
                end
            end
            mts_pkg::ST_READ:
            begin
                rcnt_next = rcnt_reg + 1'b1;
                unique case (rcnt_reg)
                    2'd0: st_raddr = ca_reg;
                    2'd1:
                    begin
                        st_raddr = cb_reg;
                        pa_next  = st_rdata;
                    end
                    2'd2:
                    begin
                        st_raddr = cc_reg;
                        pb_next  = st_rdata;
                    end
                    default:
                    begin
                        mid_next[0].x = mts_pkg::half_sum(pa_reg.x, pb_reg.x);
                        mid_next[0].y = mts_pkg::half_sum(pa_reg.y, pb_reg.y);
                        mid_next[0].z = mts_pkg::half_sum(pa_reg.z, pb_reg.z);
                        mid_next[1].x = mts_pkg::half_sum(pb_reg.x, st_rdata.x);
                        mid_next[1].y = mts_pkg::half_sum(pb_reg.y, st_rdata.y);
                        mid_next[1].z = mts_pkg::half_sum(pb_reg.z, st_rdata.z);
                        mid_next[2].x = mts_pkg::half_sum(st_rdata.x, pa_reg.x);
                        mid_next[2].y = mts_pkg::half_sum(st_rdata.y, pa_reg.y);
                        mid_next[2].z = mts_pkg::half_sum(st_rdata.z, pa_reg.z);
                        issue_next    = '0;
                        found_next    = '0;
                        full_next     = 1'b0;
                        rcnt_next     = 2'd0;
                    end
                endcase
            end
            mts_pkg::ST_SCAN:
            begin
                if (issue_reg != tbl_cnt_reg)
                begin
                    v1_next    = 1'b1;
                    issue_next = issue_reg + 1'b1;
                end
                if (v2_reg)
                begin
                    for (int e = 0; e < 3; e++)
                    begin
                        if (st_rdata == mid_reg[e])
                        begin
                            found_next[e] = 1'b1;
                            midx_next[e]  = s2_reg;
                        end
                    end
                end
            end
            mts_pkg::ST_APPEND:
            begin
                rcnt_next = rcnt_reg + 1'b1;
                st_wdata  = mid_reg[eidx];
                if (!found_reg[eidx])
                begin
                    if (store_cnt_reg < mts_pkg::CNT_W'(mts_pkg::MAX_VERTS))
                    begin
                        st_we            = 1'b1;
                        midx_next[eidx]  = store_cnt_reg[mts_pkg::IDX_W-1:0];
                        store_cnt_next   = store_cnt_reg + 1'b1;
                        if (tbl_cnt_reg < mts_pkg::CNT_W'(mts_pkg::MAX_VERTS))
                        begin
                            tb_we        = 1'b1;
                            tbl_cnt_next = tbl_cnt_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        full_next       = 1'b1;
                        midx_next[eidx] = mts_pkg::IDX_W'(mts_pkg::MAX_VERTS - 1);
                    end
                end
            end
            mts_pkg::ST_EMIT:
            begin
                ocnt_next              = ocnt_reg + 1'b1;
                result_next            = '0;
                result_next.store_full = full_reg;
                result_next.kind       = mts_pkg::KIND_TRIANGLE;
                unique case (ocnt_reg)
                    3'd0, 3'd1, 3'd2:
                    begin
                        strobe_next              = !found_reg[ocnt_reg[1:0]];
                        result_next.kind         = mts_pkg::KIND_VERTEX;
                        result_next.vertex_index = midx_reg[ocnt_reg[1:0]];
                        result_next.out_x        = mid_reg[ocnt_reg[1:0]].x;
                        result_next.out_y        = mid_reg[ocnt_reg[1:0]].y;
                        result_next.out_z        = mid_reg[ocnt_reg[1:0]].z;
                    end
                    3'd3:
                    begin
                        strobe_next            = 1'b1;
                        result_next.tri_first  = ca_reg;
                        result_next.tri_second = midx_reg[0];
                        result_next.tri_third  = midx_reg[2];
                    end
                    3'd4:
                    begin
                        strobe_next            = 1'b1;
                        result_next.tri_first  = midx_reg[2];
                        result_next.tri_second = midx_reg[1];
                        result_next.tri_third  = cc_reg;
                    end
                    3'd5:
                    begin
                        strobe_next            = 1'b1;
                        result_next.tri_first  = midx_reg[0];
                        result_next.tri_second = cb_reg;
                        result_next.tri_third  = midx_reg[1];
                    end
                    default:
                    begin
                        strobe_next            = 1'b1;
                        result_next.tri_first  = midx_reg[0];
                        result_next.tri_second = midx_reg[1];
                        result_next.tri_third  = midx_reg[2];
                        result_next.last       = 1'b1;
                    end
                endcase
            end
            default:
            begin
                rcnt_next = 2'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mts_pkg::ST_IDLE;
            store_cnt_reg <= '0;
            tbl_cnt_reg   <= '0;
            issue_reg     <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            rcnt_reg      <= '0;
            ocnt_reg      <= '0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            store_cnt_reg <= store_cnt_next;
            tbl_cnt_reg   <= tbl_cnt_next;
            issue_reg     <= issue_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            rcnt_reg      <= rcnt_next;
            ocnt_reg      <= ocnt_next;
            strobe_reg    <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_reg     <= s2_next;
        ca_reg     <= ca_next;
        cb_reg     <= cb_next;
        cc_reg     <= cc_next;
        pa_reg     <= pa_next;
        pb_reg     <= pb_next;
        mid_reg    <= mid_next;
        midx_reg   <= midx_next;
        found_reg  <= found_next;
        full_reg   <= full_next;
        result_reg <= result_next;
    end

endmodule
`default_nettype wire

### tb/sv/mts_checker.sv
`timescale 1ns / 1ps
module mts_checker (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic          busy,
    input  wire mts_pkg::cmd_t cmd,
    input  wire logic          strobe,
    input  wire mts_pkg::rsp_t result,
    output int                 fail_count,
    output int                 pending
);
    import mts_pkg::*;

    logic signed [COORD_BITS-1:0] vx [MAX_VERTS];
    logic signed [COORD_BITS-1:0] vy [MAX_VERTS];
    logic signed [COORD_BITS-1:0] vz [MAX_VERTS];
    logic [IDX_W-1:0] mid_list [MAX_VERTS];
    int vert_count;
    int mid_count;
    rsp_t expected_words[$];

    function automatic logic signed [COORD_BITS-1:0] avg2(
        input logic signed [COORD_BITS-1:0] p,
        input logic signed [COORD_BITS-1:0] q
    );
        logic signed [COORD_BITS:0] s;
        begin
            s = $signed({p[COORD_BITS-1], p}) + $signed({q[COORD_BITS-1], q});
            return s >>> 1;
        end
    endfunction

    task automatic predict_split(input cmd_t c);
        logic [IDX_W-1:0] cr [3];
        coord_t m [3];
        logic [IDX_W-1:0] idx [3];
        bit hit [3];
        bit full;
        rsp_t r;
        int n;
        begin
            full = 0;
            cr[0] = c.corner_a;
            cr[1] = c.corner_b;
            cr[2] = c.corner_c;
            for (int e = 0; e < 3; e++)
            begin
                m[e].x = avg2(vx[cr[e]], vx[cr[(e + 1) % 3]]);
                m[e].y = avg2(vy[cr[e]], vy[cr[(e + 1) % 3]]);
                m[e].z = avg2(vz[cr[e]], vz[cr[(e + 1) % 3]]);
                hit[e] = 0;
                idx[e] = '0;
            end
            for (int t = 0; t < mid_count; t++)
            begin
                n = mid_list[t];
                for (int e = 0; e < 3; e++)
                begin
                    if (vx[n] == m[e].x && vy[n] == m[e].y && vz[n] == m[e].z)
                    begin
                        hit[e] = 1;
                        idx[e] = n;
                    end
                end
            end
            for (int e = 0; e < 3; e++)
            begin
                if (!hit[e])
                begin
                    if (vert_count < MAX_VERTS)
                    begin
                        vx[vert_count] = m[e].x;
                        vy[vert_count] = m[e].y;
                        vz[vert_count] = m[e].z;
                        mid_list[mid_count] = vert_count;
                        mid_count++;
                        idx[e] = vert_count;
                        vert_count++;
                    end
                    else
                    begin
                        full = 1;
                        idx[e] = MAX_VERTS - 1;
                    end
                end
            end
            for (int e = 0; e < 3; e++)
            begin
                if (!hit[e])
                begin
                    r = '0;
                    r.kind = KIND_VERTEX;
                    r.vertex_index = idx[e];
                    r.out_x = m[e].x;
                    r.out_y = m[e].y;
                    r.out_z = m[e].z;
                    r.store_full = full;
                    expected_words.push_back(r);
                end
            end
            for (int k = 0; k < 4; k++)
            begin
                r = '0;
                r.kind = KIND_TRIANGLE;
                r.store_full = full;
                case (k)
                    0: {r.tri_first, r.tri_second, r.tri_third} = {cr[0], idx[0], idx[2]};
                    1: {r.tri_first, r.tri_second, r.tri_third} = {idx[2], idx[1], cr[2]};
                    2: {r.tri_first, r.tri_second, r.tri_third} = {idx[0], cr[1], idx[1]};
                    default:
                    begin
                        {r.tri_first, r.tri_second, r.tri_third} = {idx[0], idx[1], idx[2]};
                        r.last = 1;
                    end
                endcase
                expected_words.push_back(r);
            end
        end
    endtask

    task automatic compare_word(input rsp_t got);
        rsp_t w;
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected result word %h", got);
                fail_count++;
            end
            else
            begin
                w = expected_words.pop_front();
                if (got !== w)
                begin
                    fail_count++;
                    if (got.kind !== w.kind)
                        $error("kind exp %0d got %0d", w.kind, got.kind);
                    if (got.vertex_index !== w.vertex_index)
                        $error("vertex_index exp %0d got %0d", w.vertex_index, got.vertex_index);
                    if (got.out_x !== w.out_x)
                        $error("out_x exp %0d got %0d", w.out_x, got.out_x);
                    if (got.out_y !== w.out_y)
                        $error("out_y exp %0d got %0d", w.out_y, got.out_y);
                    if (got.out_z !== w.out_z)
                        $error("out_z exp %0d got %0d", w.out_z, got.out_z);
                    if (got.tri_first !== w.tri_first)
                        $error("tri_first exp %0d got %0d", w.tri_first, got.tri_first);
                    if (got.tri_second !== w.tri_second)
                        $error("tri_second exp %0d got %0d", w.tri_second, got.tri_second);
                    if (got.tri_third !== w.tri_third)
                        $error("tri_third exp %0d got %0d", w.tri_third, got.tri_third);
                    if (got.store_full !== w.store_full)
                        $error("store_full exp %0d got %0d", w.store_full, got.store_full);
                    if (got.last !== w.last)
                        $error("last exp %0d got %0d", w.last, got.last);
                end
            end
        end
    endtask

    initial
    begin
        fail_count = 0;
        pending = 0;
        vert_count = 0;
        mid_count = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (strobe === 1'b1)
                compare_word(result);
            if (start === 1'b1 && busy === 1'b0)
            begin
                case (cmd.action)
                    ACT_LOAD:
                        if (vert_count < MAX_VERTS)
                        begin
                            vx[vert_count] = cmd.pos_x;
                            vy[vert_count] = cmd.pos_y;
                            vz[vert_count] = cmd.pos_z;
                            vert_count++;
                        end
                    ACT_SPLIT: predict_split(cmd);
                    ACT_END: mid_count = 0;
                    default: ;
                endcase
            end
            pending = expected_words.size();
        end
    end
endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import mts_pkg::*;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    cmd_t cmd;
    logic strobe;
    rsp_t result;
    int fail_count;
    int pending;
    int loaded;

    midpoint_triangle_subdivider i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cmd(cmd), .strobe(strobe), .result(result)
    );

    mts_checker i_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .strobe(strobe), .result(result), .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("tb_top: errors");
        $finish;
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return $urandom_range(0, 7) << 8;
            default: return $urandom();
        endcase
    endfunction

    task automatic send(input cmd_t c);
        int gap;
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
            if ($urandom_range(0, 3) == 0)
                gap = 0;
            repeat (gap) @(posedge clk);
            start <= 1'b1;
            cmd <= c;
            @(posedge clk);
            while (busy !== 1'b0)
                @(posedge clk);
            start <= 1'b0;
            if (c.action == ACT_LOAD && loaded < MAX_VERTS)
                loaded++;
        end
    endtask

    task automatic load_vert(input logic [31:0] x, y, z);
        cmd_t c;
        begin
            c = '0;
            c.action = ACT_LOAD;
            c.pos_x = x;
            c.pos_y = y;
            c.pos_z = z;
            c.corner_a = $urandom();
            c.corner_b = $urandom();
            c.corner_c = $urandom();
            send(c);
        end
    endtask

    task automatic split(input int a, b, cc);
        cmd_t c;
        begin
            c = '0;
            c.action = ACT_SPLIT;
            c.pos_x = $urandom();
            c.pos_y = $urandom();
            c.pos_z = $urandom();
            c.corner_a = a;
            c.corner_b = b;
            c.corner_c = cc;
            send(c);
        end
    endtask

    task automatic end_pass(input logic [1:0] act);
        cmd_t c;
        begin
            c = '0;
            c.action = act;
            c.pos_x = $urandom();
            c.corner_a = $urandom();
            send(c);
        end
    endtask

    initial
    begin
        rst_n = 0;
        start = 0;
        cmd = '0;
        loaded = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        load_vert(32'h8000_0000, 32'h7fff_ffff, 32'h0);
        load_vert(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
        load_vert(32'hffff_ffff, 32'h0000_0001, 32'h8000_0000);
        load_vert(32'h0, 32'h0, 32'h0);
        split(0, 1, 2);
        split(0, 1, 2);
        split(2, 1, 0);
        split(3, 3, 3);
        end_pass(ACT_END);
        split(0, 1, 2);
        end_pass(2'd3);
        split(1, 2, 3);
        end_pass(ACT_END);
        for (int i = 0; i < 140; i++)
        begin
            int r;
            r = $urandom_range(0, 19);
            if (r < 6 || loaded == 0)
                load_vert(rand_coord(), rand_coord(), rand_coord());
            else if (r < 18)
            begin
                int top;
                top = loaded - 1;
                if ($urandom_range(0, 2) == 0)
                    top = (loaded < 6) ? loaded - 1 : 5;
                split($urandom_range(0, top), $urandom_range(0, top),
                      $urandom_range(0, top));
            end
            else
                end_pass(r == 18 ? ACT_END : 2'd3);
        end
        split(0, 1, 2);
        load_vert(1, 2, 3);
        split(loaded - 1, 1, 0);
        end_pass(ACT_END);
        split(0, 1, 2);
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule
